>>> design/c2dfba_pkg.sv
// shared types and codes for the convolution, bias and activation unit
package c2dfba_pkg;

    // command codes carried in the func field
    typedef enum logic [1:0] {
        FUNC_PIXEL   = 2'd0,
        FUNC_WEIGHT  = 2'd1,
        FUNC_BIAS    = 2'd2,
        FUNC_COMPUTE = 2'd3
    } t_func;

    // configuration register indexes
    localparam logic [2:0] CFG_IMAGE_WIDTH   = 3'd0;
    localparam logic [2:0] CFG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [2:0] CFG_CHANNEL_COUNT = 3'd2;
    localparam logic [2:0] CFG_FILTER_COUNT  = 3'd3;
    localparam logic [2:0] CFG_KERNEL_WIDTH  = 3'd4;
    localparam logic [2:0] CFG_KERNEL_HEIGHT = 3'd5;
    localparam logic [2:0] CFG_ACTIVATION    = 3'd6;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 6;

    // signed width of a tap coordinate: 5-bit position plus kernel offsets
    localparam int COORD_W = 8;

    // activation codes
    localparam logic ACT_LINEAR = 1'b0;
    localparam logic ACT_RELU   = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH1,
        ST_FLUSH2,
        ST_FINISH
    } t_state;

    // one command beat
    typedef struct packed {
        t_func              func;
        logic [4:0]         pos_x;
        logic [4:0]         pos_y;
        logic [1:0]         chan_index;
        logic [2:0]         filter_index;
        logic [2:0]         tap_x;
        logic [2:0]         tap_y;
        logic signed [15:0] value;
    } t_cmd;

    // one result beat
    typedef struct packed {
        logic signed [15:0] result_value;
        logic               saturated;
    } t_result;

endpackage

>>> design/c2dfba_ram.sv
// generic single-write, single-read ram with registered read data
module c2dfba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                        i_wr_data,
    input  logic                                    i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/conv2d_forward_bias_activation_unit.sv
// top level: multichannel 2-d convolution with bias, saturation and relu
//
// Command channel: a beat on i_cmd is taken at a rising edge where start is
// high and busy is low. Pixel, weight and bias writes give no result and leave
// busy low. A compute beat whose position and filter lie in the configured
// sizes raises busy and walks channel_count * kernel_height * kernel_width
// taps, one tap read from the image and weight rams a cycle, into a single
// multiply-accumulate; the bias word is read at acceptance. After the last
// tap, busy stays high through the states FLUSH1, FLUSH2 and FINISH, the last
// of which rounds and clamps; o_done then pulses for one cycle with o_result,
// in the same cycle that busy drops, so a new beat can be taken there. A
// compute beat outside the configured sizes gives no result.
// The receiver takes o_result in the o_done cycle; it cannot stall the block.
// Config channel: i_cfg_valid with o_cfg_ready (always high) writes register
// i_cfg_index; values are clamped into range, unknown indexes are ignored.
// The user must write config only while no compute is in flight; the block does not enforce it.
// Reset is synchronous, active low: config returns to its defaults and the
// sequencer goes idle; ram contents are undefined until written.
module conv2d_forward_bias_activation_unit #(
    parameter int MAX_DIM      = 32,
    parameter int MAX_CHANNELS = 4,
    parameter int MAX_FILTERS  = 8,
    parameter int MAX_KERNEL   = 5,
    parameter int FRAC_BITS    = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  c2dfba_pkg::t_cmd                     i_cmd,
    output logic                                 o_done,
    output c2dfba_pkg::t_result                  o_result,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [c2dfba_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [c2dfba_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    // store geometry
    localparam int IMG_DEPTH  = MAX_DIM * MAX_DIM * MAX_CHANNELS;
    localparam int WGT_DEPTH  = MAX_KERNEL * MAX_KERNEL * MAX_CHANNELS * MAX_FILTERS;
    localparam int BIAS_DEPTH = MAX_DIM * MAX_DIM * MAX_FILTERS;
    localparam int IMG_AW     = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
    localparam int WGT_AW     = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
    localparam int BIAS_AW    = (BIAS_DEPTH > 1) ? $clog2(BIAS_DEPTH) : 1;
    localparam int ACC_W      = 32 + $clog2(MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL + 1);
    localparam int CW         = c2dfba_pkg::COORD_W;

    // config defaults, clamped to the store bounds
    localparam logic [5:0] IW_RESET = 6'((MAX_DIM < 32) ? MAX_DIM : 32);
    localparam logic [2:0] KW_RESET = 3'((MAX_KERNEL < 3) ? MAX_KERNEL : 3);

    localparam logic signed [ACC_W:0] SAT_HI = 32767;
    localparam logic signed [ACC_W:0] SAT_LO = -32768;

    // config registers
    logic [5:0] r_iw, r_ih;
    logic [2:0] r_cc;
    logic [3:0] r_fc;
    logic [2:0] r_kw, r_kh;
    logic       r_act;
    logic [5:0] n_iw, n_ih;
    logic [5:0] n_cc, n_fc, n_kw, n_kh;

    // sequencer and datapath registers
    c2dfba_pkg::t_state r_state, n_state;
    logic [4:0]                r_px, r_py;
    logic [2:0]                r_fi;
    logic [2:0]                r_c, r_n, r_m;
    logic                      r_p1_vld;
    logic signed [31:0]        r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_done;
    c2dfba_pkg::t_result       r_result;

    // decode and control
    logic              accept;
    logic              cmd_pixel, cmd_weight, cmd_bias, cmd_compute;
    logic              cmp_in_range, cmp_go;
    logic              pix_ok, wgt_ok, bias_ok;
    logic              issue, last_m, last_n, last_c, last_tap;
    logic [2:0]        hx, hy;
    logic signed [CW-1:0] ix, iy;
    logic              tap_inside;
    logic [31:0]       img_wr_lin, img_rd_lin, wgt_wr_lin, wgt_rd_lin, bias_lin;
    logic [15:0]       img_rd_data, wgt_rd_data, bias_rd_data;
    logic signed [ACC_W-1:0] acc_q;
    logic signed [ACC_W:0]   total;
    logic signed [15:0]      clamped;
    logic                    sat;

    function automatic logic [5:0] clamp_cfg(input logic [5:0] v, input int hi);
        logic [5:0] res;
        if (v == 6'd0) begin
            res = 6'd1;
        end else if (32'(v) > hi) begin
            res = 6'(hi);
        end else begin
            res = v;
        end
        return res;
    endfunction

    assign o_cfg_ready = 1'b1;

    // config value clamping
    always_comb begin
        n_iw = clamp_cfg(i_cfg_data, MAX_DIM);
        n_ih = clamp_cfg(i_cfg_data, MAX_DIM);
        n_cc = clamp_cfg({3'b000, i_cfg_data[2:0]}, MAX_CHANNELS);
        n_fc = clamp_cfg({2'b00, i_cfg_data[3:0]}, MAX_FILTERS);
        n_kw = clamp_cfg({3'b000, i_cfg_data[2:0]}, MAX_KERNEL);
        n_kh = clamp_cfg({3'b000, i_cfg_data[2:0]}, MAX_KERNEL);
    end

    // config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iw  <= IW_RESET;
            r_ih  <= IW_RESET;
            r_cc  <= 3'd1;
            r_fc  <= 4'd1;
            r_kw  <= KW_RESET;
            r_kh  <= KW_RESET;
            r_act <= c2dfba_pkg::ACT_LINEAR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                c2dfba_pkg::CFG_IMAGE_WIDTH:   r_iw  <= n_iw;
                c2dfba_pkg::CFG_IMAGE_HEIGHT:  r_ih  <= n_ih;
                c2dfba_pkg::CFG_CHANNEL_COUNT: r_cc  <= n_cc[2:0];
                c2dfba_pkg::CFG_FILTER_COUNT:  r_fc  <= n_fc[3:0];
                c2dfba_pkg::CFG_KERNEL_WIDTH:  r_kw  <= n_kw[2:0];
                c2dfba_pkg::CFG_KERNEL_HEIGHT: r_kh  <= n_kh[2:0];
                c2dfba_pkg::CFG_ACTIVATION:    r_act <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // command decode
    assign accept = start && !busy;

    always_comb begin
        cmd_pixel   = 1'b0;
        cmd_weight  = 1'b0;
        cmd_bias    = 1'b0;
        cmd_compute = 1'b0;
        unique case (i_cmd.func)
            c2dfba_pkg::FUNC_PIXEL:   cmd_pixel   = 1'b1;
            c2dfba_pkg::FUNC_WEIGHT:  cmd_weight  = 1'b1;
            c2dfba_pkg::FUNC_BIAS:    cmd_bias    = 1'b1;
            c2dfba_pkg::FUNC_COMPUTE: cmd_compute = 1'b1;
            default: ;
        endcase
    end

    // store bounds and compute range checks
    assign pix_ok  = (32'(i_cmd.pos_x) < MAX_DIM) && (32'(i_cmd.pos_y) < MAX_DIM)
                  && (32'(i_cmd.chan_index) < MAX_CHANNELS);
    assign wgt_ok  = (32'(i_cmd.filter_index) < MAX_FILTERS)
                  && (32'(i_cmd.chan_index) < MAX_CHANNELS)
                  && (32'(i_cmd.tap_x) < MAX_KERNEL) && (32'(i_cmd.tap_y) < MAX_KERNEL);
    assign bias_ok = (32'(i_cmd.pos_x) < MAX_DIM) && (32'(i_cmd.pos_y) < MAX_DIM)
                  && (32'(i_cmd.filter_index) < MAX_FILTERS);
    assign cmp_in_range = ({1'b0, i_cmd.pos_x} < r_iw) && ({1'b0, i_cmd.pos_y} < r_ih)
                       && ({1'b0, i_cmd.filter_index} < r_fc);
    assign cmp_go = accept && cmd_compute && cmp_in_range;

    // linear store addresses
    assign img_wr_lin  = (32'(i_cmd.chan_index) * MAX_DIM + 32'(i_cmd.pos_y)) * MAX_DIM
                       + 32'(i_cmd.pos_x);
    assign wgt_wr_lin  = ((32'(i_cmd.filter_index) * MAX_CHANNELS + 32'(i_cmd.chan_index))
                       * MAX_KERNEL + 32'(i_cmd.tap_y)) * MAX_KERNEL + 32'(i_cmd.tap_x);
    assign bias_lin    = (32'(i_cmd.filter_index) * MAX_DIM + 32'(i_cmd.pos_y)) * MAX_DIM
                       + 32'(i_cmd.pos_x);

    // tap coordinate of the current step, flipped kernel around its center
    assign hx = r_kw >> 1;
    assign hy = r_kh >> 1;
    assign ix = $signed({3'b000, r_px}) + $signed({5'b00000, hx}) - $signed({5'b00000, r_m});
    assign iy = $signed({3'b000, r_py}) + $signed({5'b00000, hy}) - $signed({5'b00000, r_n});
    assign tap_inside = !ix[CW-1] && !iy[CW-1]
                     && ($unsigned(ix) < {2'b00, r_iw}) && ($unsigned(iy) < {2'b00, r_ih});

    assign img_rd_lin = (32'(r_c) * MAX_DIM + 32'(iy[CW-2:0])) * MAX_DIM + 32'(ix[CW-2:0]);
    assign wgt_rd_lin = ((32'(r_fi) * MAX_CHANNELS + 32'(r_c)) * MAX_KERNEL + 32'(r_n))
                      * MAX_KERNEL + 32'(r_m);

    // tap walk end detection
    assign last_m   = (r_m == r_kw - 3'd1);
    assign last_n   = (r_n == r_kh - 3'd1);
    assign last_c   = (r_c == r_cc - 3'd1);
    assign last_tap = last_m && last_n && last_c;

    // image, weight and bias stores
    c2dfba_ram #(.WIDTH(16), .DEPTH(IMG_DEPTH)) u_img_ram (
        .i_clk     (i_clk),
        .i_wr_en   (accept && cmd_pixel && pix_ok),
        .i_wr_addr (img_wr_lin[IMG_AW-1:0]),
        .i_wr_data (i_cmd.value),
        .i_rd_en   (issue),
        .i_rd_addr (img_rd_lin[IMG_AW-1:0]),
        .o_rd_data (img_rd_data)
    );

    c2dfba_ram #(.WIDTH(16), .DEPTH(WGT_DEPTH)) u_wgt_ram (
        .i_clk     (i_clk),
        .i_wr_en   (accept && cmd_weight && wgt_ok),
        .i_wr_addr (wgt_wr_lin[WGT_AW-1:0]),
        .i_wr_data (i_cmd.value),
        .i_rd_en   (issue),
        .i_rd_addr (wgt_rd_lin[WGT_AW-1:0]),
        .o_rd_data (wgt_rd_data)
    );

    c2dfba_ram #(.WIDTH(16), .DEPTH(BIAS_DEPTH)) u_bias_ram (
        .i_clk     (i_clk),
        .i_wr_en   (accept && cmd_bias && bias_ok),
        .i_wr_addr (bias_lin[BIAS_AW-1:0]),
        .i_wr_data (i_cmd.value),
        .i_rd_en   (cmp_go),
        .i_rd_addr (bias_lin[BIAS_AW-1:0]),
        .o_rd_data (bias_rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            c2dfba_pkg::ST_IDLE:   if (cmp_go) n_state = c2dfba_pkg::ST_RUN;
            c2dfba_pkg::ST_RUN:    if (last_tap) n_state = c2dfba_pkg::ST_FLUSH1;
            c2dfba_pkg::ST_FLUSH1: n_state = c2dfba_pkg::ST_FLUSH2;
            c2dfba_pkg::ST_FLUSH2: n_state = c2dfba_pkg::ST_FINISH;
            c2dfba_pkg::ST_FINISH: n_state = c2dfba_pkg::ST_IDLE;
            default:               n_state = c2dfba_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        busy  = 1'b1;
        issue = 1'b0;
        unique case (r_state)
            c2dfba_pkg::ST_IDLE:   busy  = 1'b0;
            c2dfba_pkg::ST_RUN:    issue = 1'b1;
            c2dfba_pkg::ST_FLUSH1: ;
            c2dfba_pkg::ST_FLUSH2: ;
            c2dfba_pkg::ST_FINISH: ;
            default:               busy  = 1'b1;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= c2dfba_pkg::ST_IDLE;
            r_p1_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_p1_vld <= issue && tap_inside;
            r_done   <= (r_state == c2dfba_pkg::ST_FINISH);
        end
    end

    // tap counters and captured command
    always_ff @(posedge i_clk) begin
        if (cmp_go) begin
            r_px <= i_cmd.pos_x;
            r_py <= i_cmd.pos_y;
            r_fi <= i_cmd.filter_index;
            r_c  <= 3'd0;
            r_n  <= 3'd0;
            r_m  <= 3'd0;
        end else if (issue) begin
            if (last_m) begin
                r_m <= 3'd0;
                if (last_n) begin
                    r_n <= 3'd0;
                    r_c <= r_c + 3'd1;
                end else begin
                    r_n <= r_n + 3'd1;
                end
            end else begin
                r_m <= r_m + 3'd1;
            end
        end
    end

    // multiply stage, padded taps contribute zero
    always_ff @(posedge i_clk) begin
        if (r_p1_vld) begin
            r_prod <= $signed(img_rd_data) * $signed(wgt_rd_data);
        end else begin
            r_prod <= 32'sd0;
        end
    end

    // accumulate stage
    always_ff @(posedge i_clk) begin
        if (cmp_go) begin
            r_acc <= '0;
        end else begin
            r_acc <= r_acc + {{(ACC_W-32){r_prod[31]}}, r_prod};
        end
    end

    // scale down with floor, add bias, clamp and activate
    always_comb begin
        acc_q = r_acc >>> FRAC_BITS;
        total = {acc_q[ACC_W-1], acc_q}
              + {{(ACC_W-15){bias_rd_data[15]}}, bias_rd_data};
        sat   = 1'b0;
        if (total > SAT_HI) begin
            clamped = 16'sh7fff;
            sat     = 1'b1;
        end else if (total < SAT_LO) begin
            clamped = -16'sh8000;
            sat     = 1'b1;
        end else begin
            clamped = total[15:0];
        end
        if (r_act == c2dfba_pkg::ACT_RELU && clamped[15]) begin
            clamped = 16'sd0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (r_state == c2dfba_pkg::ST_FINISH) begin
            r_result.result_value <= clamped;
            r_result.saturated    <= sat;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // a result only follows the finishing cycle
    a_done_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == c2dfba_pkg::ST_FINISH))
        else $error("result strobe without a finished compute");

    // the strobe lasts one cycle
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // tap counters stay inside the configured kernel and channel count
    a_tap_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == c2dfba_pkg::ST_RUN) |-> (r_m < r_kw && r_n < r_kh && r_c < r_cc))
        else $error("tap counter outside configured bounds");

    // a valid multiply input only comes from a tap issued while running
    a_mac_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1_vld |-> $past(r_state == c2dfba_pkg::ST_RUN))
        else $error("multiply fed outside the tap walk");

    // the flush states run in order FLUSH1, FLUSH2, FINISH and end in the result strobe
    a_busy_while_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == c2dfba_pkg::ST_FLUSH1) |=> (r_state == c2dfba_pkg::ST_FLUSH2) ##1
        (r_state == c2dfba_pkg::ST_FINISH) ##1 o_done)
        else $error("flush sequence broken");

endmodule
